### sv/integer_to_radix_ascii_core_macros.svh
// Assertion macros shared by the integer-to-ASCII core
`ifndef INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ITRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itra assertion failed");

// antecedent implies consequent in the next cycle
`define ITRA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itra assertion failed");

`endif

### sv/itra_pkg.sv
package itra_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 6;
  localparam int DEPTH       = VALUE_WIDTH;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int BIT_W       = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_RADIX = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO        = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 8'd87;
  localparam logic [CHAR_W-1:0] CHAR_MINUS       = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_NONE        = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_MINUS,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit_err;
    logic emit_minus;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic div_last;
    logic q_zero;
    logic neg;
    logic rd_idx_zero;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d);
    if (d < DIGIT_W'(DEC_RADIX)) begin
      return c + CHAR_ZERO;
    end
    return c + CHAR_LETTER_BASE;
  endfunction

endpackage

### sv/itra_ram.sv
module itra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/itra_dp.sv
module itra_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [itra_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [itra_pkg::RADIX_W-1:0]        radix_i,
  input  itra_pkg::cmd_t                      cmd_i,
  output itra_pkg::sts_t                      sts_o,
  output logic                                strobe_o,
  output logic [itra_pkg::CHAR_W-1:0]         char_code_o,
  output logic                                last_o,
  output logic                                bad_radix_o
);

  localparam int W = itra_pkg::VALUE_WIDTH;

  logic [W-1:0]                    q_q;
  logic [itra_pkg::RADIX_W-1:0]    rem_q;
  logic [itra_pkg::RADIX_W-1:0]    radix_q;
  logic                            neg_q;
  logic [itra_pkg::BIT_W-1:0]      bit_q;
  logic [itra_pkg::ADDR_W-1:0]     cnt_q;
  logic [itra_pkg::ADDR_W-1:0]     rd_idx_q;
  logic                            strobe_q;
  logic [itra_pkg::CHAR_W-1:0]     char_q;
  logic                            last_q;
  logic                            bad_q;

  logic [itra_pkg::RADIX_W:0]      rem_sh;
  logic                            ge;
  logic [itra_pkg::RADIX_W-1:0]    rem_d;
  logic                            neg_in;
  logic [itra_pkg::DIGIT_W-1:0]    rdata;

  // restoring division, one quotient bit per step
  always_comb begin
    rem_sh = {rem_q, q_q[W-1]};
    ge     = rem_sh >= {1'b0, radix_q};
    rem_d  = ge ? itra_pkg::RADIX_W'(rem_sh - {1'b0, radix_q})
                : itra_pkg::RADIX_W'(rem_sh);
    neg_in = (radix_i == itra_pkg::DEC_RADIX) && value_i[W-1];
  end

  itra_ram #(
    .WIDTH(itra_pkg::DIGIT_W),
    .DEPTH(itra_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(cnt_q),
    .wdata_i(rem_q),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q    <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      neg_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_err | cmd_i.emit_minus | cmd_i.emit_digit;
      if (cmd_i.load) begin
        bit_q <= '0;
        cnt_q <= '0;
        neg_q <= neg_in;
      end
      if (cmd_i.div_step) begin
        bit_q <= bit_q + 1'b1;
      end
      if (cmd_i.store) begin
        bit_q <= '0;
        cnt_q <= cnt_q + 1'b1;
        if (q_q == '0) begin
          rd_idx_q <= cnt_q;
        end
      end
      if (cmd_i.emit_digit) begin
        rd_idx_q <= rd_idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q     <= neg_in ? W'(0 - value_i) : value_i;
      rem_q   <= '0;
      radix_q <= radix_i;
    end
    if (cmd_i.div_step) begin
      q_q   <= {q_q[W-2:0], ge};
      rem_q <= rem_d;
    end
    if (cmd_i.store) begin
      rem_q <= '0;
    end
    if (cmd_i.emit_err) begin
      char_q <= itra_pkg::CHAR_NONE;
      last_q <= 1'b1;
      bad_q  <= 1'b1;
    end
    if (cmd_i.emit_minus) begin
      char_q <= itra_pkg::CHAR_MINUS;
      last_q <= 1'b0;
      bad_q  <= 1'b0;
    end
    if (cmd_i.emit_digit) begin
      char_q <= itra_pkg::digit_char(rdata);
      last_q <= rd_idx_q == '0;
      bad_q  <= 1'b0;
    end
  end

  assign sts_o.radix_ok    = (radix_i >= itra_pkg::RADIX_MIN) &&
                             (radix_i <= itra_pkg::RADIX_MAX);
  assign sts_o.div_last    = bit_q == itra_pkg::BIT_W'(W - 1);
  assign sts_o.q_zero      = q_q == '0;
  assign sts_o.neg         = neg_q;
  assign sts_o.rd_idx_zero = rd_idx_q == '0;

  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign bad_radix_o = bad_q;

endmodule

### sv/itra_ctrl.sv
`include "integer_to_radix_ascii_core_macros.svh"

module itra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  itra_pkg::sts_t sts_i,
  output itra_pkg::cmd_t cmd_o,
  output logic           busy_o
);

  itra_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      itra_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (sts_i.radix_ok) begin
            cmd_o.load = 1'b1;
            state_d    = itra_pkg::ST_DIV;
          end else begin
            cmd_o.emit_err = 1'b1;
          end
        end
      end
      itra_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = itra_pkg::ST_STORE;
        end
      end
      itra_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        if (!sts_i.q_zero) begin
          state_d = itra_pkg::ST_DIV;
        end else if (sts_i.neg) begin
          state_d = itra_pkg::ST_MINUS;
        end else begin
          state_d = itra_pkg::ST_READ;
        end
      end
      itra_pkg::ST_MINUS: begin
        cmd_o.emit_minus = 1'b1;
        state_d          = itra_pkg::ST_READ;
      end
      itra_pkg::ST_READ: begin
        state_d = itra_pkg::ST_EMIT;
      end
      itra_pkg::ST_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        state_d = sts_i.rd_idx_zero ? itra_pkg::ST_IDLE : itra_pkg::ST_READ;
      end
      default: begin
        state_d = itra_pkg::ST_IDLE;
      end
    endcase
  end

  `ITRA_ASSERT_NXT(a_div_runs, (state_q == itra_pkg::ST_DIV) && !sts_i.div_last, state_q == itra_pkg::ST_DIV)
  `ITRA_ASSERT_NXT(a_last_digit_ends, cmd_o.emit_digit && sts_i.rd_idx_zero, state_q == itra_pkg::ST_IDLE)
  `ITRA_ASSERT_IMP(a_store_after_div, state_q == itra_pkg::ST_STORE, $past(state_q) == itra_pkg::ST_DIV)

endmodule

### sv/integer_to_radix_ascii_core.sv
// Converts a signed 32-bit value to ASCII digits in radix 2 to 36, most significant
// first, one character per strobe_o pulse with last_o on the final one. Only a negative
// value in radix 10 gets a leading '-'; other radices print the unsigned bit pattern.
// A transaction is taken when start_i is high and busy_o is low. An invalid radix is
// answered by a single result (char 0, last and bad_radix set) in the next cycle and
// leaves busy_o low. A valid conversion keeps busy_o high until it emits its last digit:
// each digit comes from a 32-step restoring divider (one quotient bit per cycle) and is
// then stored in the digit memory; a '-' follows if needed, and each character waits in a
// read state for the registered read of the digit memory before it is emitted. Results are shown for
// exactly one cycle and the receiver cannot stall them; the last result may still be
// on the ports in the cycle a new transaction is taken.
module integer_to_radix_ascii_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic signed [itra_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [itra_pkg::RADIX_W-1:0]            radix_i,
  output logic                                    strobe_o,
  output logic [itra_pkg::CHAR_W-1:0]             char_code_o,
  output logic                                    last_o,
  output logic                                    bad_radix_o
);

  itra_pkg::cmd_t cmd;
  itra_pkg::sts_t sts;

  itra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  itra_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .radix_i    (radix_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .strobe_o   (strobe_o),
    .char_code_o(char_code_o),
    .last_o     (last_o),
    .bad_radix_o(bad_radix_o)
  );

endmodule
